### rtl/brp_pkg.sv
// Shared types and constants for the boot recovery policy block.
`default_nettype none
package brp_pkg;

  localparam int unsigned CntW = 32;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [CntW-1:0] DefTrialLimit = 32'd3;
  localparam logic [CntW-1:0] DefPhaseLimit = 32'd3;
  localparam logic [CntW-1:0] DefStormLimit = 32'd8;

  localparam int unsigned AddrW = 4;
  localparam logic [1:0] RegTrialLimit = 2'd0;
  localparam logic [1:0] RegPhaseLimit = 2'd1;
  localparam logic [1:0] RegStormLimit = 2'd2;

  typedef enum logic [2:0] {
    ST_OTHER        = 3'd0,
    ST_INSTALLING   = 3'd1,
    ST_CAND_VALID   = 3'd2,
    ST_BACKUP_VALID = 3'd3,
    ST_TRIAL        = 3'd4,
    ST_RB_PENDING   = 3'd5,
    ST_ROLLING_BACK = 3'd6,
    ST_FAILED       = 3'd7
  } state_t;

  typedef enum logic [1:0] {
    ACT_JUMP     = 2'd0,
    ACT_HOLD     = 2'd1,
    ACT_INSTALL  = 2'd2,
    ACT_ROLLBACK = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_NO_APP = 2'd1,
    ERR_PHASE  = 2'd2,
    ERR_STORM  = 2'd3
  } err_t;

  typedef struct packed {
    logic [CntW-1:0] trial;
    logic [CntW-1:0] phase;
    logic [CntW-1:0] storm;
  } limits_t;

  typedef struct packed {
    state_t          upgrade_state;
    logic [CntW-1:0] trial_boots;
    logic [CntW-1:0] watchdog_count;
    logic [CntW-1:0] phase_count;
    logic            cause_power_on;
    logic            cause_watchdog;
    logic            cause_pin;
    logic            cause_software;
    logic            image_valid;
  } item_t;

  typedef struct packed {
    action_t         boot_action;
    state_t          next_state;
    logic [CntW-1:0] next_trial_boots;
    logic [CntW-1:0] next_watchdog_count;
    logic [CntW-1:0] next_phase_count;
    err_t            error_code;
    logic            must_persist;
  } result_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

### rtl/boot_recovery_policy.sv
// Top level of the boot recovery policy: input register, decision, result register.
// A transaction accepted into the input register passes to the result register and is offered from there.
// Throughput: one transaction per cycle; the result register stalls while its result is held
// by out_ready low, and the input register stalls with it only while it also holds one.
// Reset: rst (synchronous) empties both registers and clears the three limit registers.
`default_nettype none
module boot_recovery_policy (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               upgrade_state,
  input  wire logic [31:0]              trial_boots,
  input  wire logic [31:0]              watchdog_count,
  input  wire logic [31:0]              phase_count,
  input  wire logic                     cause_power_on,
  input  wire logic                     cause_watchdog,
  input  wire logic                     cause_pin,
  input  wire logic                     cause_software,
  input  wire logic                     image_valid,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [1:0]               boot_action,
  output logic      [2:0]               next_state,
  output logic      [31:0]              next_trial_boots,
  output logic      [31:0]              next_watchdog_count,
  output logic      [31:0]              next_phase_count,
  output logic      [1:0]               error_code,
  output logic                          must_persist,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [brp_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready
);

  brp_pkg::limits_t limits;
  brp_pkg::item_t   item;
  brp_pkg::result_t res_next;
  brp_pkg::result_t res;
  logic             item_valid;
  logic             res_load;

  brp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  brp_core u_core (
    .item   (item),
    .limits (limits),
    .res    (res_next)
  );

  assign res_load = !out_valid || out_ready;
  assign in_ready = !item_valid || res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (res_load) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.upgrade_state  <= brp_pkg::state_t'(upgrade_state);
      item.trial_boots    <= trial_boots;
      item.watchdog_count <= watchdog_count;
      item.phase_count    <= phase_count;
      item.cause_power_on <= cause_power_on;
      item.cause_watchdog <= cause_watchdog;
      item.cause_pin      <= cause_pin;
      item.cause_software <= cause_software;
      item.image_valid    <= image_valid;
    end
    if (res_load && item_valid) begin
      res <= res_next;
    end
  end

  assign boot_action         = res.boot_action;
  assign next_state          = res.next_state;
  assign next_trial_boots    = res.next_trial_boots;
  assign next_watchdog_count = res.next_watchdog_count;
  assign next_phase_count    = res.next_phase_count;
  assign error_code          = res.error_code;
  assign must_persist        = res.must_persist;

endmodule
`default_nettype wire

### rtl/brp_cfg.sv
// Limit registers on the APB port, with zero mapped to the default limits.
`default_nettype none
module brp_cfg (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [brp_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  output brp_pkg::limits_t              limits
);

  logic [31:0] trial_limit;
  logic [31:0] phase_limit;
  logic [31:0] storm_limit;
  logic        wr_en;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      trial_limit <= '0;
      phase_limit <= '0;
      storm_limit <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        brp_pkg::RegTrialLimit: trial_limit <= pwdata;
        brp_pkg::RegPhaseLimit: phase_limit <= pwdata;
        brp_pkg::RegStormLimit: storm_limit <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      brp_pkg::RegTrialLimit: prdata = trial_limit;
      brp_pkg::RegPhaseLimit: prdata = phase_limit;
      brp_pkg::RegStormLimit: prdata = storm_limit;
      default:                prdata = '0;
    endcase
  end

  assign limits.trial = (trial_limit != '0) ? trial_limit : brp_pkg::DefTrialLimit;
  assign limits.phase = (phase_limit != '0) ? phase_limit : brp_pkg::DefPhaseLimit;
  assign limits.storm = (storm_limit != '0) ? storm_limit : brp_pkg::DefStormLimit;

endmodule
`default_nettype wire

### rtl/brp_core.sv
// Reset accounting and boot decision for one registered transaction.
`default_nettype none
module brp_core (
  input  wire brp_pkg::item_t   item,
  input  wire brp_pkg::limits_t limits,
  output brp_pkg::result_t      res
);

  logic [brp_pkg::CntW-1:0] wd_acc;
  logic                     wd_persist;
  logic                     hold_or_jump;
  logic                     phase_hit;

  always_comb begin
    wd_acc     = item.watchdog_count;
    wd_persist = 1'b0;
    if (item.cause_power_on) begin
      wd_acc     = '0;
      wd_persist = (item.watchdog_count != '0);
    end else if (item.cause_watchdog) begin
      wd_acc     = brp_pkg::sat_inc(item.watchdog_count);
      wd_persist = 1'b1;
    end else if (item.cause_pin && !item.cause_software && item.watchdog_count != '0) begin
      wd_acc     = '0;
      wd_persist = 1'b1;
    end
  end

  assign phase_hit = (item.phase_count >= limits.phase);

  always_comb begin
    res.boot_action         = brp_pkg::ACT_JUMP;
    res.next_state          = item.upgrade_state;
    res.next_trial_boots    = item.trial_boots;
    res.next_watchdog_count = wd_acc;
    res.next_phase_count    = item.phase_count;
    res.error_code          = brp_pkg::ERR_NONE;
    res.must_persist        = wd_persist;
    hold_or_jump            = 1'b0;

    case (item.upgrade_state)
      brp_pkg::ST_INSTALLING, brp_pkg::ST_CAND_VALID, brp_pkg::ST_BACKUP_VALID: begin
        res.must_persist = 1'b1;
        if (phase_hit) begin
          res.next_state       = brp_pkg::ST_RB_PENDING;
          res.next_phase_count = '0;
          res.error_code       = brp_pkg::ERR_PHASE;
          res.boot_action      = brp_pkg::ACT_ROLLBACK;
        end else begin
          res.next_state       = brp_pkg::ST_INSTALLING;
          res.next_phase_count = brp_pkg::sat_inc(item.phase_count);
          res.boot_action      = brp_pkg::ACT_INSTALL;
        end
      end
      brp_pkg::ST_TRIAL: begin
        res.must_persist = 1'b1;
        if (item.trial_boots >= limits.trial) begin
          res.next_state       = brp_pkg::ST_RB_PENDING;
          res.next_phase_count = '0;
          res.boot_action      = brp_pkg::ACT_ROLLBACK;
        end else if (!item.image_valid) begin
          res.next_state       = brp_pkg::ST_RB_PENDING;
          res.next_phase_count = '0;
          res.error_code       = brp_pkg::ERR_NO_APP;
          res.boot_action      = brp_pkg::ACT_ROLLBACK;
        end else begin
          res.next_trial_boots = brp_pkg::sat_inc(item.trial_boots);
        end
      end
      brp_pkg::ST_RB_PENDING, brp_pkg::ST_ROLLING_BACK: begin
        res.must_persist = 1'b1;
        if (phase_hit) begin
          res.next_state = brp_pkg::ST_FAILED;
          res.error_code = brp_pkg::ERR_PHASE;
          hold_or_jump   = 1'b1;
        end else begin
          res.next_state       = brp_pkg::ST_ROLLING_BACK;
          res.next_phase_count = brp_pkg::sat_inc(item.phase_count);
          res.boot_action      = brp_pkg::ACT_ROLLBACK;
        end
      end
      default: begin
        if (item.cause_watchdog && wd_acc >= limits.storm) begin
          res.next_state       = brp_pkg::ST_RB_PENDING;
          res.next_phase_count = '0;
          res.error_code       = brp_pkg::ERR_STORM;
          res.boot_action      = brp_pkg::ACT_ROLLBACK;
          res.must_persist     = 1'b1;
        end else begin
          hold_or_jump = 1'b1;
        end
      end
    endcase

    if (hold_or_jump) begin
      if (item.image_valid) begin
        res.boot_action = brp_pkg::ACT_JUMP;
      end else begin
        res.boot_action = brp_pkg::ACT_HOLD;
        if (res.error_code == brp_pkg::ERR_NONE) begin
          res.error_code = brp_pkg::ERR_NO_APP;
        end
      end
    end
  end

endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the boot recovery policy block: random and directed resets.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOffCycles = 60;
  localparam logic [3:0] CauseNone = 4'b0000;
  localparam logic [3:0] CausePor = 4'b1000;
  localparam logic [3:0] CauseWdg = 4'b0100;
  localparam logic [3:0] CausePin = 4'b0010;
  localparam logic [3:0] CauseSw = 4'b0001;

  class boot_plan_board;
    brp_pkg::limits_t lim;
    brp_pkg::result_t pending_plans[$];
    int unsigned mismatches;

    function new();
      lim = '0;
      mismatches = 0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [brp_pkg::CntW-1:0] value);
      case (idx)
        brp_pkg::RegTrialLimit: lim.trial = value;
        brp_pkg::RegPhaseLimit: lim.phase = value;
        brp_pkg::RegStormLimit: lim.storm = value;
        default: ;
      endcase
    endfunction

    function logic [brp_pkg::CntW-1:0] step_count(logic [brp_pkg::CntW-1:0] v);
      return (v == brp_pkg::CntMax) ? v : v + 32'd1;
    endfunction

    function brp_pkg::result_t plan_boot(brp_pkg::item_t it);
      brp_pkg::result_t r;
      logic [brp_pkg::CntW-1:0] trial_cap;
      logic [brp_pkg::CntW-1:0] phase_cap;
      logic [brp_pkg::CntW-1:0] storm_cap;
      logic settle;
      trial_cap = (lim.trial != '0) ? lim.trial : brp_pkg::DefTrialLimit;
      phase_cap = (lim.phase != '0) ? lim.phase : brp_pkg::DefPhaseLimit;
      storm_cap = (lim.storm != '0) ? lim.storm : brp_pkg::DefStormLimit;
      r.boot_action = brp_pkg::ACT_JUMP;
      r.next_state = it.upgrade_state;
      r.next_trial_boots = it.trial_boots;
      r.next_watchdog_count = it.watchdog_count;
      r.next_phase_count = it.phase_count;
      r.error_code = brp_pkg::ERR_NONE;
      r.must_persist = 1'b0;
      settle = 1'b0;

      if (it.cause_power_on) begin
        if (it.watchdog_count != '0) begin
          r.next_watchdog_count = '0;
          r.must_persist = 1'b1;
        end
      end else if (it.cause_watchdog) begin
        r.next_watchdog_count = step_count(it.watchdog_count);
        r.must_persist = 1'b1;
      end else if (it.cause_pin && !it.cause_software && it.watchdog_count != '0) begin
        r.next_watchdog_count = '0;
        r.must_persist = 1'b1;
      end

      case (it.upgrade_state)
        brp_pkg::ST_INSTALLING, brp_pkg::ST_CAND_VALID, brp_pkg::ST_BACKUP_VALID: begin
          r.must_persist = 1'b1;
          if (it.phase_count >= phase_cap) begin
            r.next_state = brp_pkg::ST_RB_PENDING;
            r.next_phase_count = '0;
            r.error_code = brp_pkg::ERR_PHASE;
            r.boot_action = brp_pkg::ACT_ROLLBACK;
          end else begin
            r.next_state = brp_pkg::ST_INSTALLING;
            r.next_phase_count = step_count(it.phase_count);
            r.boot_action = brp_pkg::ACT_INSTALL;
          end
        end
        brp_pkg::ST_TRIAL: begin
          r.must_persist = 1'b1;
          if (it.trial_boots >= trial_cap) begin
            r.next_state = brp_pkg::ST_RB_PENDING;
            r.next_phase_count = '0;
            r.boot_action = brp_pkg::ACT_ROLLBACK;
          end else if (!it.image_valid) begin
            r.next_state = brp_pkg::ST_RB_PENDING;
            r.next_phase_count = '0;
            r.error_code = brp_pkg::ERR_NO_APP;
            r.boot_action = brp_pkg::ACT_ROLLBACK;
          end else begin
            r.next_trial_boots = step_count(it.trial_boots);
          end
        end
        brp_pkg::ST_RB_PENDING, brp_pkg::ST_ROLLING_BACK: begin
          r.must_persist = 1'b1;
          if (it.phase_count >= phase_cap) begin
            r.next_state = brp_pkg::ST_FAILED;
            r.error_code = brp_pkg::ERR_PHASE;
            settle = 1'b1;
          end else begin
            r.next_state = brp_pkg::ST_ROLLING_BACK;
            r.next_phase_count = step_count(it.phase_count);
            r.boot_action = brp_pkg::ACT_ROLLBACK;
          end
        end
        default: begin
          if (it.cause_watchdog && r.next_watchdog_count >= storm_cap) begin
            r.next_state = brp_pkg::ST_RB_PENDING;
            r.next_phase_count = '0;
            r.error_code = brp_pkg::ERR_STORM;
            r.boot_action = brp_pkg::ACT_ROLLBACK;
            r.must_persist = 1'b1;
          end else begin
            settle = 1'b1;
          end
        end
      endcase

      if (settle) begin
        if (it.image_valid) begin
          r.boot_action = brp_pkg::ACT_JUMP;
        end else begin
          r.boot_action = brp_pkg::ACT_HOLD;
          if (r.error_code == brp_pkg::ERR_NONE) r.error_code = brp_pkg::ERR_NO_APP;
        end
      end
      return r;
    endfunction

    function void note_request(brp_pkg::item_t it);
      pending_plans.push_back(plan_boot(it));
    endfunction

    function int unsigned pending();
      return pending_plans.size();
    endfunction

    function void report_field(string field, logic [brp_pkg::CntW-1:0] want,
                               logic [brp_pkg::CntW-1:0] got);
      if (got !== want)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_plan(brp_pkg::result_t got);
      brp_pkg::result_t want;
      if (pending_plans.size() == 0) begin
        $display("%0t: result with no transaction pending, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_plans.pop_front();
      if (got !== want) begin
        mismatches++;
        report_field("boot_action", 32'(want.boot_action), 32'(got.boot_action));
        report_field("next_state", 32'(want.next_state), 32'(got.next_state));
        report_field("next_trial_boots", want.next_trial_boots, got.next_trial_boots);
        report_field("next_watchdog_count", want.next_watchdog_count, got.next_watchdog_count);
        report_field("next_phase_count", want.next_phase_count, got.next_phase_count);
        report_field("error_code", 32'(want.error_code), 32'(got.error_code));
        report_field("must_persist", 32'(want.must_persist), 32'(got.must_persist));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] upgrade_state = '0;
  logic [31:0] trial_boots = '0;
  logic [31:0] watchdog_count = '0;
  logic [31:0] phase_count = '0;
  logic cause_power_on = 1'b0;
  logic cause_watchdog = 1'b0;
  logic cause_pin = 1'b0;
  logic cause_software = 1'b0;
  logic image_valid = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] boot_action;
  logic [2:0] next_state;
  logic [31:0] next_trial_boots;
  logic [31:0] next_watchdog_count;
  logic [31:0] next_phase_count;
  logic [1:0] error_code;
  logic must_persist;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [brp_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  boot_plan_board plans = new();
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_calls = 0;
  brp_pkg::item_t last_sent;
  logic chain_live = 1'b0;

  boot_recovery_policy u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .upgrade_state(upgrade_state),
    .trial_boots(trial_boots),
    .watchdog_count(watchdog_count),
    .phase_count(phase_count),
    .cause_power_on(cause_power_on),
    .cause_watchdog(cause_watchdog),
    .cause_pin(cause_pin),
    .cause_software(cause_software),
    .image_valid(image_valid),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .boot_action(boot_action),
    .next_state(next_state),
    .next_trial_boots(next_trial_boots),
    .next_watchdog_count(next_watchdog_count),
    .next_phase_count(next_phase_count),
    .error_code(error_code),
    .must_persist(must_persist),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic brp_pkg::item_t make_request(brp_pkg::state_t st, logic [31:0] tb,
                                                  logic [31:0] wd, logic [31:0] ph,
                                                  logic [3:0] causes, logic valid);
    brp_pkg::item_t it;
    it.upgrade_state = st;
    it.trial_boots = tb;
    it.watchdog_count = wd;
    it.phase_count = ph;
    {it.cause_power_on, it.cause_watchdog, it.cause_pin, it.cause_software} = causes;
    it.image_valid = valid;
    return it;
  endfunction

  function automatic logic [31:0] pick_count(logic [31:0] around);
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'($urandom_range(12));
      2: return brp_pkg::CntMax - 32'($urandom_range(2));
      3: return around - 32'd1 + 32'($urandom_range(2));
      default: return $urandom;
    endcase
  endfunction

  function automatic brp_pkg::item_t random_request();
    brp_pkg::item_t it;
    logic [3:0] causes;
    if ($urandom_range(1) != 0) causes = 4'b0001 << $urandom_range(3);
    else causes = 4'($urandom);
    it = make_request(brp_pkg::state_t'($urandom_range(7)), pick_count(plans.lim.trial),
                      pick_count(plans.lim.storm), pick_count(plans.lim.phase), causes,
                      1'($urandom_range(1)));
    return it;
  endfunction

  // Follow the persisted state across successive resets most of the time.
  function automatic brp_pkg::item_t next_request();
    brp_pkg::item_t it;
    brp_pkg::result_t carry;
    it = random_request();
    if (chain_live && $urandom_range(99) < 70) begin
      carry = plans.plan_boot(last_sent);
      it.upgrade_state = carry.next_state;
      it.trial_boots = carry.next_trial_boots;
      it.watchdog_count = carry.next_watchdog_count;
      it.phase_count = carry.next_phase_count;
      it.image_valid = ($urandom_range(7) != 0);
    end
    return it;
  endfunction

  task automatic offer(brp_pkg::item_t it);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    upgrade_state <= it.upgrade_state;
    trial_boots <= it.trial_boots;
    watchdog_count <= it.watchdog_count;
    phase_count <= it.phase_count;
    cause_power_on <= it.cause_power_on;
    cause_watchdog <= it.cause_watchdog;
    cause_pin <= it.cause_pin;
    cause_software <= it.cause_software;
    image_valid <= it.image_valid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    plans.note_request(it);
    last_sent = it;
    chain_live = 1'b1;
  endtask

  task automatic run_burst(int unsigned count);
    for (int unsigned i = 0; i < count; i++) offer(next_request());
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (plans.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= brp_pkg::AddrW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    plans.set_limit(idx, value);
  endtask

  task automatic write_limits(logic [31:0] trial, logic [31:0] phase, logic [31:0] storm);
    write_limit(brp_pkg::RegTrialLimit, trial);
    write_limit(brp_pkg::RegPhaseLimit, phase);
    write_limit(brp_pkg::RegStormLimit, storm);
  endtask

  initial begin
    int unsigned served;
    int unsigned hold_left;
    served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        plans.check_plan(brp_pkg::result_t'({boot_action, next_state, next_trial_boots,
                                             next_watchdog_count, next_phase_count,
                                             error_code, must_persist}));
      if (served != hold_calls) begin
        served = hold_calls;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int s = 0; s < 8; s++)
      offer(make_request(brp_pkg::state_t'(s), 32'd0, 32'd0, 32'd0, CauseNone, 1'(s)));
    offer(make_request(brp_pkg::ST_OTHER, 32'd0, 32'd5, 32'd0, CausePor, 1'b1));
    offer(make_request(brp_pkg::ST_OTHER, 32'd0, 32'd0, 32'd0, CausePor | CauseWdg, 1'b1));
    offer(make_request(brp_pkg::ST_OTHER, 32'd0, 32'd6, 32'd0, CauseWdg, 1'b1));
    offer(make_request(brp_pkg::ST_OTHER, 32'd0, 32'd7, 32'd0, CauseWdg, 1'b1));
    offer(make_request(brp_pkg::ST_FAILED, 32'd0, brp_pkg::CntMax, 32'd0, CauseWdg, 1'b0));
    offer(make_request(brp_pkg::ST_FAILED, 32'd0, 32'd100, 32'd0, CauseNone, 1'b0));
    offer(make_request(brp_pkg::ST_OTHER, 32'd0, 32'd5, 32'd0, CausePin, 1'b1));
    offer(make_request(brp_pkg::ST_OTHER, 32'd0, 32'd5, 32'd0, CausePin | CauseSw, 1'b1));
    offer(make_request(brp_pkg::ST_OTHER, brp_pkg::CntMax, 32'd5, brp_pkg::CntMax,
                       4'b1111, 1'b0));
    offer(make_request(brp_pkg::ST_OTHER, 32'd0, 32'd9, 32'd0, CauseSw, 1'b1));
    offer(make_request(brp_pkg::ST_INSTALLING, 32'd0, 32'd0, 32'd3, CauseNone, 1'b1));
    offer(make_request(brp_pkg::ST_BACKUP_VALID, 32'd0, 32'd0, 32'd2, CausePin, 1'b0));
    offer(make_request(brp_pkg::ST_TRIAL, 32'd3, 32'd0, 32'd1, CauseNone, 1'b1));
    offer(make_request(brp_pkg::ST_TRIAL, 32'd2, 32'd0, 32'd1, CauseNone, 1'b0));
    offer(make_request(brp_pkg::ST_TRIAL, 32'd0, 32'd7, 32'd0, CauseWdg, 1'b1));
    offer(make_request(brp_pkg::ST_RB_PENDING, 32'd0, 32'd0, 32'd3, CauseNone, 1'b0));
    offer(make_request(brp_pkg::ST_ROLLING_BACK, 32'd0, 32'd0, brp_pkg::CntMax, CauseNone,
                       1'b1));
    settle_block();

    write_limits(32'd1, 32'd1, 32'd1);
    send_idle = 21;
    recv_idle = 62;
    run_burst(100);
    hold_calls++;
    run_burst(300);
    settle_block();

    write_limits(brp_pkg::CntMax, brp_pkg::CntMax, brp_pkg::CntMax);
    send_idle = 62;
    recv_idle = 21;
    run_burst(400);
    settle_block();

    write_limits(32'($urandom_range(10, 2)), 32'($urandom_range(10, 2)),
                 32'($urandom_range(10, 2)));
    send_idle = 0;
    recv_idle = 0;
    run_burst(200);
    settle_block();

    write_limits(32'd0, 32'd0, 32'd0);
    run_burst(200);
    settle_block();

    if (plans.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
